@@ rtl/nfcr_pkg.sv @@
// shared constants, types and helper functions of the type 2 tag read responder
package nfcr_pkg;

  localparam int TAG_BYTES    = 144;
  localparam int MSG_CAPACITY = 128;
  localparam int ADDR_W       = $clog2(TAG_BYTES);
  localparam int POS_W        = 11;
  localparam int READ_BYTES   = 16;
  localparam int HDR_BYTES    = 18;
  localparam int MSG_BASE     = 18;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = 1;

  localparam logic [1:0] F_LOAD   = 2'd0;
  localparam logic [1:0] F_FRAME  = 2'd1;
  localparam logic [1:0] F_DETECT = 2'd2;
  localparam logic [1:0] F_LOST   = 2'd3;

  localparam logic [7:0] CMD_READ  = 8'h30;
  localparam logic [7:0] CMD_WRITE = 8'hA2;
  localparam logic [7:0] BCC_SALT  = 8'h88;
  localparam logic [7:0] MAKER_ID  = 8'h04;
  localparam logic [7:0] CC_MAGIC  = 8'hE1;
  localparam logic [7:0] CC_VER    = 8'h10;
  localparam logic [7:0] CC_SIZE   = 8'h10;
  localparam logic [7:0] CC_ACCESS = 8'h00;
  localparam logic [7:0] TLV_NDEF  = 8'h03;
  localparam logic [7:0] TLV_TERM  = 8'hFE;

  localparam logic [7:0] READ_TX_BITS = 8'(READ_BYTES * 8);
  localparam logic [7:0] NAK_TX_BITS  = 8'd4;

  localparam logic [1:0] REG_TAG_UID_ADDR = 2'd0;

  typedef enum logic [2:0] {
    K_DATA   = 3'd0,
    K_NAK    = 3'd1,
    K_LISTEN = 3'd2,
    K_ACCEPT = 3'd3,
    K_REJECT = 3'd4,
    K_EVENT  = 3'd5,
    K_IDLE   = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_READ   = 2'd1,
    OP_RESULT = 2'd2
  } op_code_t;

  typedef struct packed {
    op_code_t            code;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_pos;
    logic [7:0]          wr_byte;
    logic                last_byte;
    logic                build;
    kind_t               kind;
    logic [7:0]          len;
    logic [23:0]         uid;
    logic [ADDR_W-1:0]   rd_off;
    logic [15:0]         reads;
    logic [15:0]         detects;
    logic [15:0]         losts;
  } op_t;

  // image header byte at step idx, step HDR_BYTES is the terminator
  function automatic logic [7:0] hdr_byte(input logic [4:0] idx, input logic [23:0] uid,
                                          input logic [7:0] len);
    logic [7:0] b;
    case (idx) inside
      5'd0:           b = MAKER_ID;
      5'd1:           b = uid[7:0];
      5'd2:           b = uid[15:8];
      5'd3:           b = MAKER_ID ^ uid[7:0] ^ uid[15:8] ^ uid[23:16] ^ BCC_SALT;
      5'd4:           b = uid[23:16];
      [5'd5:5'd11]:   b = 8'h00;
      5'd12:          b = CC_MAGIC;
      5'd13:          b = CC_VER;
      5'd14:          b = CC_SIZE;
      5'd15:          b = CC_ACCESS;
      5'd16:          b = TLV_NDEF;
      5'd17:          b = len;
      5'(HDR_BYTES):  b = TLV_TERM;
      default:        b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/nfcr_if.sv @@
// request and result channel interfaces
interface nfcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  ndef_byte;
  logic        ndef_final;
  logic [7:0]  cmd_byte;
  logic [7:0]  arg_byte;
  logic [10:0] rx_bit_count;

  modport source(output valid, func, ndef_byte, ndef_final, cmd_byte, arg_byte,
                 rx_bit_count, input ready);
  modport sink(input valid, func, ndef_byte, ndef_final, cmd_byte, arg_byte,
               rx_bit_count, output ready);
endinterface

interface nfcr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_out;
  logic [7:0]  tx_bits;
  logic        run_last;
  logic [15:0] reads_served;
  logic [15:0] fields_detected;
  logic [15:0] fields_lost;

  modport source(output valid, kind, data_out, tx_bits, run_last, reads_served,
                 fields_detected, fields_lost, input ready);
  modport sink(input valid, kind, data_out, tx_bits, run_last, reads_served,
               fields_detected, fields_lost, output ready);
endinterface

@@ rtl/nfcr_front.sv @@
// request classifier: owns load index, active flag and counters, emits operations
module nfcr_front
  import nfcr_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  nfcr_in_if.sink       in_if,
  input  logic [23:0]   tag_uid,
  input  logic          q_full,
  output logic          q_push,
  output op_t           q_op
);

  logic [7:0]       li_r, li_nxt;
  logic             active_r, active_nxt;
  logic [15:0]      reads_r, reads_nxt;
  logic [15:0]      det_r, det_nxt;
  logic [15:0]      lost_r, lost_nxt;
  logic             accept;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] len;
  logic [POS_W-1:0] off;
  logic             fits;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;
  assign q_push      = accept;

  assign pos  = POS_W'(li_r) + POS_W'(MSG_BASE);
  assign len  = POS_W'(li_r) + POS_W'(1);
  assign off  = POS_W'({in_if.arg_byte, 2'b00});
  assign fits = (len + POS_W'(4) <= POS_W'(MSG_CAPACITY)) && (len <= POS_W'(255))
             && (len + POS_W'(19) <= POS_W'(TAG_BYTES));

  always_comb begin
    li_nxt     = li_r;
    active_nxt = active_r;
    reads_nxt  = reads_r;
    det_nxt    = det_r;
    lost_nxt   = lost_r;
    q_op           = '0;
    q_op.code      = OP_RESULT;
    q_op.kind      = K_IDLE;
    q_op.uid       = tag_uid;
    q_op.len       = len[7:0];
    q_op.wr_pos    = pos[ADDR_W-1:0];
    q_op.wr_byte   = in_if.ndef_byte;
    q_op.rd_off    = off[ADDR_W-1:0];
    case (in_if.func)
      F_LOAD: begin
        active_nxt     = 1'b0;
        q_op.code      = OP_LOAD;
        q_op.wr_en     = pos < POS_W'(TAG_BYTES);
        q_op.last_byte = in_if.ndef_final;
        if (!in_if.ndef_final) begin
          if (li_r != 8'hFF) begin
            li_nxt = li_r + 8'd1;
          end
        end else begin
          li_nxt     = '0;
          active_nxt = fits;
          q_op.build = fits;
          q_op.kind  = fits ? K_ACCEPT : K_REJECT;
        end
      end
      F_DETECT: begin
        if (active_r) begin
          det_nxt   = det_r + 16'd1;
          q_op.kind = K_EVENT;
        end
      end
      F_LOST: begin
        if (active_r) begin
          lost_nxt  = lost_r + 16'd1;
          q_op.kind = K_EVENT;
        end
      end
      F_FRAME: begin
        if (active_r) begin
          if (in_if.rx_bit_count[10:4] == '0) begin
            q_op.kind = K_LISTEN;
          end else if (in_if.cmd_byte == CMD_READ) begin
            if (off + POS_W'(READ_BYTES) > POS_W'(TAG_BYTES)) begin
              q_op.kind = K_NAK;
            end else begin
              reads_nxt = reads_r + 16'd1;
              q_op.code = OP_READ;
              q_op.kind = K_DATA;
            end
          end else if (in_if.cmd_byte == CMD_WRITE) begin
            q_op.kind = K_NAK;
          end else begin
            q_op.kind = K_LISTEN;
          end
        end
      end
      default: begin
        q_op.kind = K_IDLE;
      end
    endcase
    q_op.reads   = reads_nxt;
    q_op.detects = det_nxt;
    q_op.losts   = lost_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      li_r     <= '0;
      active_r <= 1'b0;
      reads_r  <= '0;
      det_r    <= '0;
      lost_r   <= '0;
    end else if (accept) begin
      li_r     <= li_nxt;
      active_r <= active_nxt;
      reads_r  <= reads_nxt;
      det_r    <= det_nxt;
      lost_r   <= lost_nxt;
    end
  end

endmodule

@@ rtl/nfcr_queue.sv @@
// short operation queue between classifier and executor
module nfcr_queue
  import nfcr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head,
  output logic full,
  output logic empty
);

  op_t                entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, rp_r;
  logic [Q_PTR_W:0]   cnt_r;
  logic               do_push, do_pop;

  assign full    = cnt_r == (Q_PTR_W+1)'(Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wp_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/nfcr_back.sv @@
// operation executor: tag store, image build sweep, read streaming, result register
module nfcr_back
  import nfcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  op_t       q_head,
  output logic      q_pop,
  nfcr_out_if.source out_if
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_WBYTE  = 5'b00010,
    S_BUILD  = 5'b00100,
    S_RESULT = 5'b01000,
    S_READ   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [4:0]        idx_r, idx_nxt;
  logic [4:0]        iss_r, iss_nxt;
  logic [4:0]        em_r, em_nxt;
  logic              rdv_r, rdv_nxt;

  logic [7:0]        mem [TAG_BYTES];
  logic [TAG_BYTES-1:0] vld_r;
  logic [7:0]        rd_data_r;
  logic              rd_ok_r;
  logic              we, re;
  logic [ADDR_W-1:0] wa, ra;
  logic [7:0]        wd;

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [7:0]        out_data_r, out_tx_r;
  logic              out_last_r;
  logic [15:0]       out_reads_r, out_det_r, out_lost_r;

  logic              can_load, ld, ld_last;
  kind_t             ld_kind;
  logic [7:0]        ld_data, ld_tx;
  logic              issue, drain;

  assign can_load = !out_valid_r || out_if.ready;
  assign ra       = op_r.rd_off + ADDR_W'(iss_r);
  assign issue    = (state_r == S_READ) && (iss_r != 5'(READ_BYTES)) && (!rdv_r || can_load);
  assign drain    = (state_r == S_READ) && rdv_r && can_load;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    idx_nxt   = idx_r;
    iss_nxt   = iss_r;
    em_nxt    = em_r;
    rdv_nxt   = rdv_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    wa        = op_r.wr_pos;
    wd        = op_r.wr_byte;
    re        = 1'b0;
    ld        = 1'b0;
    ld_kind   = op_r.kind;
    ld_data   = 8'h00;
    ld_tx     = 8'h00;
    ld_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          op_nxt = q_head;
          case (q_head.code)
            OP_LOAD: state_nxt = S_WBYTE;
            OP_READ: begin
              state_nxt = S_READ;
              iss_nxt   = '0;
              em_nxt    = '0;
              rdv_nxt   = 1'b0;
            end
            default: state_nxt = S_RESULT;
          endcase
        end
      end
      S_WBYTE: begin
        we = op_r.wr_en;
        if (!op_r.last_byte) begin
          state_nxt = S_IDLE;
        end else if (op_r.build) begin
          state_nxt = S_BUILD;
          idx_nxt   = '0;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_BUILD: begin
        we = 1'b1;
        wd = hdr_byte(idx_r, op_r.uid, op_r.len);
        if (idx_r == 5'(HDR_BYTES)) begin
          // terminator goes right after the message
          wa        = ADDR_W'(MSG_BASE) + ADDR_W'(op_r.len);
          state_nxt = S_RESULT;
        end else begin
          wa      = ADDR_W'(idx_r);
          idx_nxt = idx_r + 5'd1;
        end
      end
      S_RESULT: begin
        if (can_load) begin
          ld        = 1'b1;
          ld_tx     = (op_r.kind == K_NAK) ? NAK_TX_BITS : 8'h00;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        re      = issue;
        ld_kind = K_DATA;
        ld_data = rd_ok_r ? rd_data_r : 8'h00;
        ld_tx   = READ_TX_BITS;
        ld_last = em_r == 5'(READ_BYTES - 1);
        if (drain) begin
          ld     = 1'b1;
          em_nxt = em_r + 5'd1;
          if (ld_last) begin
            state_nxt = S_IDLE;
          end
        end
        if (issue) begin
          iss_nxt = iss_r + 5'd1;
          rdv_nxt = 1'b1;
        end else if (drain) begin
          rdv_nxt = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // byte store, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

  // never-written bytes read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wa] <= 1'b1;
      end
      if (re) begin
        rd_ok_r <= vld_r[ra];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    idx_r <= idx_nxt;
    iss_r <= iss_nxt;
    em_r  <= em_nxt;
    if (ld) begin
      out_kind_r  <= ld_kind;
      out_data_r  <= ld_data;
      out_tx_r    <= ld_tx;
      out_last_r  <= ld_last;
      out_reads_r <= op_r.reads;
      out_det_r   <= op_r.detects;
      out_lost_r  <= op_r.losts;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= rdv_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.kind            = out_kind_r;
  assign out_if.data_out        = out_data_r;
  assign out_if.tx_bits         = out_tx_r;
  assign out_if.run_last        = out_last_r;
  assign out_if.reads_served    = out_reads_r;
  assign out_if.fields_detected = out_det_r;
  assign out_if.fields_lost     = out_lost_r;

endmodule

@@ rtl/nfc_type2_tag_read_responder.sv @@
// top level of the read-only type 2 tag responder
//
// requests arrive on in_if (valid/ready): a message byte to load, a reader frame,
// or a field-detected / field-lost event. results leave on out_if (valid/ready),
// one per request, sixteen for a good READ, none for a non-final message byte.
// each result carries the three event counters as they stand after its request.
// the tag uid register sits on the cfg_ apb port at byte address 0 and is
// sampled when the final message byte arrives.
// the front classifies a request in the cycle it is accepted and pushes one
// operation into a two-entry queue; the back pops it once it is idle.
// a simple result passes through the queue and the back's result register; an image
// build adds one store write per header byte and one for the terminator; a READ
// streams its bytes through the single store read port, one byte per cycle while
// the receiver is ready.
// a new request is taken whenever the queue has room, even while a result waits.
// reset (rst_n low, synchronous) clears the counters, the active flag, the load
// index, the store valid bits and the queue; the store reads as zero until written.
// when the receiver stalls, the result register holds, the back stops, and
// the queue fills; in_if.ready drops once both queue entries are taken.
module nfc_type2_tag_read_responder
  import nfcr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  nfcr_in_if.sink      in_if,
  nfcr_out_if.source   out_if,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [23:0] uid_r;
  logic        uid_wr;
  logic        q_full, q_empty, q_push, q_pop;
  op_t         push_op, head_op;

  // apb: no wait states, only the uid register is decoded
  assign cfg_pready = 1'b1;
  assign uid_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == REG_TAG_UID_ADDR);
  assign cfg_prdata = (cfg_paddr == REG_TAG_UID_ADDR) ? 32'(uid_r) : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uid_r <= '0;
    end else if (uid_wr) begin
      uid_r <= cfg_pwdata[23:0];
    end
  end

  // classify each request against load index, active flag and counters
  nfcr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .tag_uid (uid_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_op    (push_op)
  );

  // decouples classification from store access and result delivery
  nfcr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head    (head_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  // store writes, image header sweep, read streaming and result register
  nfcr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (head_op),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule
